// ===== design/arpc_pkg.sv =====
`default_nettype none
package arpc_pkg;

    localparam logic [1:0] CMD_RECEIVE  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP   = 2'd1;
    localparam logic [1:0] CMD_DISCOVER = 2'd2;

    localparam logic [1:0] SEND_NONE    = 2'd0;
    localparam logic [1:0] SEND_REQUEST = 2'd1;
    localparam logic [1:0] SEND_REPLY   = 2'd2;

    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;

    localparam logic [15:0] HTYPE_ETH      = 16'd1;
    localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
    localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
    localparam logic [47:0] BCAST_MAC      = {6{8'hff}};

    localparam logic REG_OWN_MAC = 1'b0;
    localparam logic REG_OWN_IP  = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] operation;
        logic [47:0] sender_mac;
        logic [31:0] src_ip;
        logic [31:0] tgt_ip;
    } item_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [47:0] dest_mac;
        logic [47:0] out_target_mac;
        logic [31:0] out_tgt_ip;
        logic        found;
        logic [47:0] found_mac;
        logic        learned;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] mac;
    } entry_t;

endpackage
`default_nettype wire

// ===== design/arpc_table.sv =====
`default_nettype none
module arpc_table #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  wire                    aclk,
    input  wire                    wr_en,
    input  wire [IDX_W-1:0]        wr_addr,
    input  wire arpc_pkg::entry_t  wr_data,
    input  wire [IDX_W-1:0]        rd_addr,
    output arpc_pkg::entry_t       rd_data
);
    import arpc_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== design/arpc_seq.sv =====
`default_nettype none
module arpc_seq #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4,
    parameter int CNT_W   = 5
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire [31:0]              own_ip,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire arpc_pkg::item_t    in_item,
    output logic                    out_valid,
    input  wire                     out_ready,
    output arpc_pkg::result_t       out_result,
    output logic                    wr_en,
    output logic [IDX_W-1:0]        wr_addr,
    output arpc_pkg::entry_t        wr_data,
    output logic [IDX_W-1:0]        rd_addr,
    input  wire arpc_pkg::entry_t   rd_data
);
    import arpc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic              learn_reg, learn_next;
    logic [31:0]       key_reg, key_next;
    logic [47:0]       smac_reg, smac_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [47:0]       hit_mac_reg, hit_mac_next;
    logic              free_reg, free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;
    logic              m_valid_reg, m_valid_next;
    logic              hdr_ok;
    logic              ip_match;

    assign hdr_ok = (in_item.hw_type == HTYPE_ETH) && (in_item.proto_type == PTYPE_IPV4)
                 && (in_item.hw_len == HW_ADDR_LEN) && (in_item.proto_len == PROTO_ADDR_LEN);

    // shared compare unit for the table scan
    assign ip_match = rd_data.valid && (rd_data.ip == key_reg);

    assign rd_addr = cnt_reg[IDX_W-1:0];

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        learn_next    = learn_reg;
        key_next      = key_reg;
        smac_next     = smac_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_mac_next  = hit_mac_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        ptr_next      = ptr_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !out_ready;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[IDX_W-1:0];
        wr_data       = '0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ENTRIES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    res_next     = '0;
                    key_next     = in_item.tgt_ip;
                    smac_next    = in_item.sender_mac;
                    learn_next   = 1'b0;
                    cnt_next     = '0;
                    pend_next    = 1'b0;
                    hit_next     = 1'b0;
                    free_next    = 1'b0;
                    state_next   = ST_DONE;
                    case (in_item.command)
                        CMD_RECEIVE: begin
                            if (hdr_ok) begin
                                if (in_item.operation == OP_REQUEST
                                        && in_item.tgt_ip == own_ip) begin
                                    res_next.send_kind      = SEND_REPLY;
                                    res_next.dest_mac       = in_item.sender_mac;
                                    res_next.out_target_mac = in_item.sender_mac;
                                    res_next.out_tgt_ip     = in_item.src_ip;
                                end
                                if (in_item.operation == OP_REPLY) begin
                                    key_next   = in_item.src_ip;
                                    learn_next = 1'b1;
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                        CMD_LOOKUP: begin
                            state_next = ST_SCAN;
                        end
                        CMD_DISCOVER: begin
                            res_next.send_kind  = SEND_REQUEST;
                            res_next.dest_mac   = BCAST_MAC;
                            res_next.out_tgt_ip = in_item.tgt_ip;
                        end
                        default: begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (cnt_reg != CNT_W'(ENTRIES)) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    if (ip_match && !hit_reg) begin
                        hit_next     = 1'b1;
                        hit_idx_next = pidx_reg;
                        hit_mac_next = rd_data.mac;
                    end
                    if (!rd_data.valid && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = pidx_reg;
                    end
                end
                if (cnt_reg == CNT_W'(ENTRIES) && !pend_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (learn_reg) begin
                    wr_en         = 1'b1;
                    wr_data.valid = 1'b1;
                    wr_data.ip    = key_reg;
                    wr_data.mac   = smac_reg;
                    if (hit_reg) begin
                        wr_addr = hit_idx_reg;
                    end else if (free_reg) begin
                        wr_addr = free_idx_reg;
                    end else begin
                        wr_addr = ptr_reg;
                        if (ptr_reg == IDX_W'(ENTRIES - 1)) begin
                            ptr_next = '0;
                        end else begin
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                    res_next.learned = 1'b1;
                end else begin
                    res_next.found     = hit_reg;
                    res_next.found_mac = hit_reg ? hit_mac_reg : 48'd0;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || out_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
        pidx_reg     <= pidx_next;
        learn_reg    <= learn_next;
        key_reg      <= key_next;
        smac_reg     <= smac_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_mac_reg  <= hit_mac_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign out_valid  = m_valid_reg;
    assign out_result = out_reg;

endmodule
`default_nettype wire

// ===== design/arp_responder_and_cache_top.sv =====
// flow: receive with a request, discover and malformed packets go from ST_IDLE straight to ST_DONE
// flow: a lookup or a learned reply passes ST_SCAN, ST_FINISH and ST_DONE, paced by the one-entry-a-cycle
//   table scan through a single ip compare and the registered table read port
// throughput: one transaction at a time, the next is taken once the result is in the output register
// reset: aresetn is synchronous and active low; after it a clearing pass over all ENTRIES slots
//   empties the table while the input side is not ready; configuration writes are taken throughout
`default_nettype none
module arp_responder_and_cache_top #(
    parameter int ENTRIES = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // hw_type, proto_type, hw_len, proto_len, operation, sender_mac, src_ip, tgt_ip
    input  wire [175:0]  s_tdata,
    // command
    input  wire [1:0]    s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // dest_mac, out_target_mac, out_tgt_ip, found, found_mac, learned, zero pad
    output logic [183:0] m_tdata,
    // send_kind
    output logic [1:0]   m_tuser,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire          cfg_index,
    input  wire [47:0]   cfg_wdata
);
    import arpc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [47:0]      own_mac_reg;
    logic [31:0]      own_ip_reg;
    item_t            item;
    result_t          res;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OWN_MAC: own_mac_reg <= cfg_wdata;
                REG_OWN_IP:  own_ip_reg  <= cfg_wdata[31:0];
                default:     own_ip_reg  <= own_ip_reg;
            endcase
        end
    end

    assign item.command    = s_tuser;
    assign item.hw_type    = s_tdata[15:0];
    assign item.proto_type = s_tdata[31:16];
    assign item.hw_len     = s_tdata[39:32];
    assign item.proto_len  = s_tdata[47:40];
    assign item.operation  = s_tdata[63:48];
    assign item.sender_mac = s_tdata[111:64];
    assign item.src_ip     = s_tdata[143:112];
    assign item.tgt_ip     = s_tdata[175:144];

    arpc_seq #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .own_ip     (own_ip_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    arpc_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tuser = res.send_kind;
    assign m_tdata = {6'd0, res.learned, res.found_mac, res.found, res.out_tgt_ip,
                      res.out_target_mac, res.dest_mac};

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a transaction is in flight");

    a_found_or_learned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res.found && res.learned))
        else $error("lookup hit and learn flagged together");

    a_miss_mac_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !res.found) |-> (res.found_mac == 48'd0))
        else $error("found_mac set without a hit");

    a_request_bcast: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.send_kind == SEND_REQUEST) |->
            (res.dest_mac == BCAST_MAC && res.out_target_mac == 48'd0))
        else $error("request not broadcast");
`endif

endmodule
`default_nettype wire
